### hw/rtl/kwe_pkg.sv
package kwe_pkg;

  localparam int AGENT_COUNT      = 256;
  localparam int WEALTH_FRAC_BITS = 16;
  localparam int AGENT_SPAN       = (AGENT_COUNT < 256) ? AGENT_COUNT : 256;

  localparam int AGENT_W  = 8;
  localparam int PAIR_W   = 2 * AGENT_W;
  localparam int WEALTH_W = 40;
  localparam int Q16_W    = 16;
  localparam int COUNT_W  = 16;
  localparam int MONEY_W  = 24;
  localparam int CFG_W    = 32;
  localparam int PADDR_W  = 4;
  localparam int MUL_W    = 32;
  localparam int MUL_PW   = 2 * MUL_W;

  localparam logic CMD_INIT = 1'b0;
  localparam logic CMD_XFER = 1'b1;

  typedef enum logic [1:0] {
    REG_SAVING = 2'd0,
    REG_ALPHA  = 2'd1,
    REG_GAMMA  = 2'd2,
    REG_START  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [Q16_W-1:0]   saving_fraction;
    logic [Q16_W-1:0]   alpha_exponent;
    logic [Q16_W-1:0]   gamma_exponent;
    logic [MONEY_W-1:0] opening_balance;
  } cfg_t;

  typedef struct packed {
    logic               command;
    logic [AGENT_W-1:0] agent_a;
    logic [AGENT_W-1:0] agent_b;
    logic [Q16_W-1:0]   share_draw;
    logic [Q16_W-1:0]   accept_draw;
  } job_t;

  typedef struct packed {
    logic                accepted;
    logic [WEALTH_W-1:0] wealth_a;
    logic [WEALTH_W-1:0] wealth_b;
    logic [COUNT_W-1:0]  pair_count;
    logic [COUNT_W-1:0]  max_count;
    logic [COUNT_W-1:0]  max_rises;
  } result_t;

  typedef struct packed {
    logic start;
    logic take;
  } eng_ctl_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } eng_sts_t;

endpackage

### hw/rtl/kwe_if.sv
interface kwe_req_if;
  import kwe_pkg::*;
  logic               valid;
  logic               ready;
  logic               command;
  logic [AGENT_W-1:0] agent_a;
  logic [AGENT_W-1:0] agent_b;
  logic [Q16_W-1:0]   share_draw;
  logic [Q16_W-1:0]   accept_draw;
  modport source (output valid, command, agent_a, agent_b, share_draw, accept_draw,
                  input ready);
  modport sink (input valid, command, agent_a, agent_b, share_draw, accept_draw,
                output ready);
endinterface

interface kwe_rsp_if;
  import kwe_pkg::*;
  logic                valid;
  logic                ready;
  logic                accepted;
  logic [WEALTH_W-1:0] wealth_a;
  logic [WEALTH_W-1:0] wealth_b;
  logic [COUNT_W-1:0]  pair_count;
  logic [COUNT_W-1:0]  max_count;
  logic [COUNT_W-1:0]  max_rises;
  modport source (output valid, accepted, wealth_a, wealth_b, pair_count, max_count,
                  max_rises, input ready);
  modport sink (input valid, accepted, wealth_a, wealth_b, pair_count, max_count,
                max_rises, output ready);
endinterface

### hw/rtl/kwe_ram.sv
module kwe_ram #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/kwe_mul.sv
module kwe_mul (
  input  logic                    clk,
  input  logic [kwe_pkg::MUL_W-1:0]  a,
  input  logic [kwe_pkg::MUL_W-1:0]  b,
  output logic [kwe_pkg::MUL_PW-1:0] prod
);
  import kwe_pkg::*;

  always_ff @(posedge clk) begin
    prod <= MUL_PW'(a) * MUL_PW'(b);
  end

endmodule

### hw/rtl/kwe_engine.sv
module kwe_engine (
  input  logic              clk,
  input  logic              rst,
  input  kwe_pkg::cfg_t     cfg,
  input  kwe_pkg::job_t     job,
  input  kwe_pkg::eng_ctl_t ctl,
  output kwe_pkg::eng_sts_t sts,
  output kwe_pkg::result_t  res
);
  import kwe_pkg::*;

  localparam int FB    = WEALTH_FRAC_BITS;
  localparam int SH_L  = (FB >= 16) ? FB - 16 : 0;
  localparam int SH_R  = (FB >= 16) ? 0 : 16 - FB;
  localparam int HALF  = WEALTH_W / 2;
  localparam int NZ_W  = $clog2(WEALTH_W);
  localparam int E_LW  = 6;
  localparam int LOG_W = E_LW + 16;
  localparam int E_W   = Q16_W + LOG_W;
  localparam int N_W   = E_W + 1 - 12;
  localparam int IP_W  = N_W - 15;
  localparam int P_W   = 58;
  localparam int M_W   = 57;
  localparam int T_W   = 59;
  localparam int D_W   = T_W - 16;
  localparam int S_W   = 45;
  localparam int SQ_W  = 64;
  localparam logic [WEALTH_W-1:0] WEALTH_MAX = '1;

  typedef enum logic [5:0] {
    S_SWEEP, S_IDLE, S_RDA, S_RDB, S_RDC, S_GAP, S_NORM, S_SQ_MUL, S_SQ_UPD,
    S_LOG_DONE, S_E_MUL1, S_E_MUL2, S_E_MUL3, S_E_SPLIT, S_SQRT_INIT, S_SQRT_STEP,
    S_WEIGHT, S_DECIDE, S_X0, S_X1, S_X2, S_X3, S_X4, S_X5, S_X6, S_X7, S_X8, S_X9,
    S_X10, S_WR_A, S_WR_B, S_COUNT, S_DONE
  } state_t;

  state_t              state;
  logic [PAIR_W-1:0]   sweep_addr;
  logic                sweep_report;
  logic [WEALTH_W-1:0] fill;
  logic [COUNT_W-1:0]  peak;
  logic [COUNT_W-1:0]  tally;
  job_t                job_r;
  logic [WEALTH_W-1:0] wa;
  logic [WEALTH_W-1:0] wb;
  logic [COUNT_W-1:0]  cnt;
  logic [WEALTH_W-1:0] norm_s;
  logic [NZ_W-1:0]     norm_z;
  logic [E_LW-1:0]     log_e;
  logic [MUL_W-1:0]    m;
  logic [15:0]         frac;
  logic [3:0]          sq_i;
  logic                log_phase;
  logic [LOG_W-1:0]    lg;
  logic [LOG_W-1:0]    lc;
  logic [E_W-1:0]      e_p1;
  logic [E_W-1:0]      nd;
  logic [IP_W-1:0]     ip;
  logic [15:0]         f_r;
  logic [MUL_W-1:0]    x;
  logic [3:0]          ex_i;
  logic [SQ_W-1:0]     rem;
  logic [SQ_W-1:0]     root;
  logic [SQ_W-1:0]     sqb;
  logic                acc;
  logic [P_W-1:0]      pacc;
  logic [P_W-1:0]      qacc;
  logic [M_W-1:0]      mag;
  logic                neg;
  logic [T_W-1:0]      tacc;

  logic [MUL_W-1:0]    mul_a;
  logic [MUL_W-1:0]    mul_b;
  logic [MUL_PW-1:0]   prod;
  logic                w_we;
  logic [AGENT_W-1:0]  w_waddr;
  logic [WEALTH_W-1:0] w_wdata;
  logic [AGENT_W-1:0]  w_raddr;
  logic [WEALTH_W-1:0] w_rdata;
  logic                c_we;
  logic [PAIR_W-1:0]   c_waddr;
  logic [COUNT_W-1:0]  c_wdata;
  logic [COUNT_W-1:0]  c_rdata;

  logic                a_ok;
  logic                b_ok;
  logic [PAIR_W-1:0]   key;
  logic [WEALTH_W-1:0] fill_calc;
  logic [WEALTH_W-1:0] gap;
  logic [LOG_W-1:0]    logv;
  logic [N_W-1:0]      n_val;
  logic [IP_W-1:0]     ip_val;
  logic [SQ_W-1:0]     sq_t;
  logic [SQ_W-1:0]     root_next;
  logic [MUL_W-1:0]    sq_val;
  logic [MUL_W-1:0]    w_full;
  logic [16:0]         ome;
  logic [16:0]         oml;
  logic [D_W-1:0]      d_val;
  logic signed [S_W-1:0] wa_s;
  logic signed [S_W-1:0] wb_s;
  logic signed [S_W-1:0] d_s;
  logic signed [S_W-1:0] sum_a;
  logic signed [S_W-1:0] sum_b;
  logic [COUNT_W-1:0]  cnt_new;
  logic [COUNT_W-1:0]  peak_new;
  logic [COUNT_W-1:0]  tally_new;

  function automatic logic [WEALTH_W-1:0] clamp_wealth(input logic signed [S_W-1:0] v);
    if (v < 0) begin
      return '0;
    end else if (v > $signed(S_W'(WEALTH_MAX))) begin
      return WEALTH_MAX;
    end
    return v[WEALTH_W-1:0];
  endfunction

  kwe_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  kwe_ram #(.ADDR_W(AGENT_W), .DATA_W(WEALTH_W)) u_wealth (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata), .raddr(w_raddr),
    .rdata(w_rdata)
  );

  kwe_ram #(.ADDR_W(PAIR_W), .DATA_W(COUNT_W)) u_count (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata), .raddr(key),
    .rdata(c_rdata)
  );

  assign a_ok = {1'b0, job_r.agent_a} < (AGENT_W + 1)'(AGENT_SPAN);
  assign b_ok = {1'b0, job_r.agent_b} < (AGENT_W + 1)'(AGENT_SPAN);
  assign key  = (job_r.agent_a <= job_r.agent_b) ? {job_r.agent_a, job_r.agent_b}
                                                 : {job_r.agent_b, job_r.agent_a};
  assign fill_calc = WEALTH_W'((64'(cfg.opening_balance) << SH_L) >> SH_R);
  assign gap    = (wa >= wb) ? wa - wb : wb - wa;
  assign logv   = {log_e, frac};
  assign n_val  = N_W'(((E_W + 1)'(nd) + (E_W + 1)'(4095)) >> 12);
  assign ip_val = IP_W'(n_val[N_W-1:16]) + IP_W'(n_val[15:0] != '0);
  assign sq_t   = root + sqb;
  assign root_next = (rem >= sq_t) ? (root >> 1) + sqb : root >> 1;
  assign sq_val = prod[61:30];
  assign w_full = x >> (5'(14) + ip[4:0]);
  assign ome    = 17'h10000 - 17'(job_r.share_draw);
  assign oml    = 17'h10000 - 17'(cfg.saving_fraction);
  assign d_val  = tacc[T_W-1:16];
  assign wa_s   = $signed(S_W'(wa));
  assign wb_s   = $signed(S_W'(wb));
  assign d_s    = $signed(S_W'(d_val));
  assign sum_a  = neg ? wa_s - d_s : wa_s + d_s;
  assign sum_b  = neg ? wb_s + d_s : wb_s - d_s;
  assign cnt_new   = (cnt == '1) ? cnt : cnt + 1'b1;
  assign peak_new  = (peak < cnt_new) ? cnt_new : peak;
  assign tally_new = ((peak < cnt_new) && (tally != '1)) ? tally + 1'b1 : tally;

  assign sts.idle      = (state == S_IDLE);
  assign sts.res_valid = (state == S_DONE);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SQ_MUL: begin
        mul_a = m;
        mul_b = m;
      end
      S_E_MUL1: begin
        mul_a = MUL_W'(cfg.gamma_exponent);
        mul_b = MUL_W'(lc);
      end
      S_E_MUL2: begin
        mul_a = MUL_W'(cfg.alpha_exponent);
        mul_b = MUL_W'(lg);
      end
      S_X0: begin
        mul_a = MUL_W'(wb[HALF-1:0]);
        mul_b = MUL_W'(job_r.share_draw);
      end
      S_X1: begin
        mul_a = MUL_W'(wb[WEALTH_W-1:HALF]);
        mul_b = MUL_W'(job_r.share_draw);
      end
      S_X2: begin
        mul_a = MUL_W'(wa[HALF-1:0]);
        mul_b = MUL_W'(ome);
      end
      S_X3: begin
        mul_a = MUL_W'(wa[WEALTH_W-1:HALF]);
        mul_b = MUL_W'(ome);
      end
      S_X6: begin
        mul_a = MUL_W'(mag[15:0]);
        mul_b = MUL_W'(oml);
      end
      S_X7: begin
        mul_a = MUL_W'(mag[16+HALF-1:16]);
        mul_b = MUL_W'(oml);
      end
      S_X8: begin
        mul_a = MUL_W'(mag[M_W-1:16+HALF]);
        mul_b = MUL_W'(oml);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    w_we    = 1'b0;
    w_waddr = job_r.agent_a;
    w_wdata = wa;
    w_raddr = (state == S_RDB) ? job_r.agent_b : job_r.agent_a;
    c_we    = 1'b0;
    c_waddr = key;
    c_wdata = cnt_new;
    unique case (state)
      S_SWEEP: begin
        w_we    = (sweep_addr[PAIR_W-1:AGENT_W] == '0);
        w_waddr = sweep_addr[AGENT_W-1:0];
        w_wdata = ({1'b0, sweep_addr[AGENT_W-1:0]} < (AGENT_W + 1)'(AGENT_SPAN)) ? fill
                                                                               : '0;
        c_we    = 1'b1;
        c_waddr = sweep_addr;
        c_wdata = '0;
      end
      S_WR_A: begin
        w_we = 1'b1;
      end
      S_WR_B: begin
        w_we    = 1'b1;
        w_waddr = job_r.agent_b;
        w_wdata = wb;
      end
      S_COUNT: begin
        c_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_SWEEP;
      sweep_addr   <= '0;
      sweep_report <= 1'b0;
      fill         <= '0;
      peak         <= '0;
      tally        <= '0;
    end else begin
      unique case (state)
        S_SWEEP: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_addr == '1) begin
            if (sweep_report) begin
              res.accepted   <= 1'b0;
              res.wealth_a   <= a_ok ? fill : '0;
              res.wealth_b   <= b_ok ? fill : '0;
              res.pair_count <= '0;
              res.max_count  <= '0;
              res.max_rises  <= '0;
              state          <= S_DONE;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (ctl.start) begin
            job_r <= job;
            if (job.command == CMD_INIT) begin
              fill         <= fill_calc;
              peak         <= '0;
              tally        <= '0;
              sweep_addr   <= '0;
              sweep_report <= 1'b1;
              state        <= S_SWEEP;
            end else begin
              state <= S_RDA;
            end
          end
        end
        S_RDA: begin
          if (a_ok && b_ok) begin
            state <= S_RDB;
          end else begin
            res.accepted   <= 1'b0;
            res.wealth_a   <= '0;
            res.wealth_b   <= '0;
            res.pair_count <= '0;
            res.max_count  <= peak;
            res.max_rises  <= tally;
            state          <= S_DONE;
          end
        end
        S_RDB: begin
          wa    <= w_rdata;
          cnt   <= c_rdata;
          state <= S_RDC;
        end
        S_RDC: begin
          wb    <= w_rdata;
          state <= S_GAP;
        end
        S_GAP: begin
          if ((cfg.alpha_exponent == '0) || ((gap >> FB) == '0)) begin
            acc   <= 1'b1;
            state <= S_DECIDE;
          end else begin
            norm_s    <= gap;
            norm_z    <= '0;
            log_phase <= 1'b0;
            state     <= S_NORM;
          end
        end
        S_NORM: begin
          if (norm_s[WEALTH_W-1]) begin
            m     <= MUL_W'(norm_s[WEALTH_W-1 -: 31]);
            log_e <= E_LW'(WEALTH_W - 1) - E_LW'(norm_z);
            frac  <= '0;
            sq_i  <= '0;
            state <= S_SQ_MUL;
          end else begin
            norm_s <= norm_s << 1;
            norm_z <= norm_z + 1'b1;
          end
        end
        S_SQ_MUL: begin
          state <= S_SQ_UPD;
        end
        S_SQ_UPD: begin
          frac <= {frac[14:0], sq_val[MUL_W-1]};
          m    <= sq_val[MUL_W-1] ? sq_val >> 1 : sq_val;
          sq_i <= sq_i + 1'b1;
          state <= (sq_i == 4'd15) ? S_LOG_DONE : S_SQ_MUL;
        end
        S_LOG_DONE: begin
          if (!log_phase) begin
            lg        <= logv - LOG_W'(FB * 65536);
            norm_s    <= WEALTH_W'({1'b0, cnt} + (COUNT_W + 1)'(1));
            norm_z    <= '0;
            log_phase <= 1'b1;
            state     <= S_NORM;
          end else begin
            lc    <= logv;
            state <= S_E_MUL1;
          end
        end
        S_E_MUL1: begin
          state <= S_E_MUL2;
        end
        S_E_MUL2: begin
          e_p1  <= prod[E_W-1:0];
          state <= S_E_MUL3;
        end
        S_E_MUL3: begin
          if (e_p1 >= prod[E_W-1:0]) begin
            acc   <= 1'b1;
            state <= S_DECIDE;
          end else begin
            nd    <= prod[E_W-1:0] - e_p1;
            state <= S_E_SPLIT;
          end
        end
        S_E_SPLIT: begin
          if (ip_val >= IP_W'(18)) begin
            acc   <= (job_r.accept_draw == '0);
            state <= S_DECIDE;
          end else begin
            ip    <= ip_val;
            f_r   <= 16'(~n_val[15:0] + 16'd1);
            x     <= 32'h4000_0000;
            ex_i  <= '0;
            state <= S_SQRT_INIT;
          end
        end
        S_SQRT_INIT: begin
          rem   <= (SQ_W'(x) << f_r[ex_i]) << 30;
          root  <= '0;
          sqb   <= SQ_W'(1) << 62;
          state <= S_SQRT_STEP;
        end
        S_SQRT_STEP: begin
          if (rem >= sq_t) begin
            rem <= rem - sq_t;
          end
          root <= root_next;
          sqb  <= sqb >> 2;
          if (sqb[0]) begin
            x     <= root_next[MUL_W-1:0];
            ex_i  <= ex_i + 1'b1;
            state <= (ex_i == 4'd15) ? S_WEIGHT : S_SQRT_INIT;
          end
        end
        S_WEIGHT: begin
          acc   <= w_full >= MUL_W'(job_r.accept_draw);
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (!acc) begin
            res.accepted   <= 1'b0;
            res.wealth_a   <= wa;
            res.wealth_b   <= wb;
            res.pair_count <= cnt;
            res.max_count  <= peak;
            res.max_rises  <= tally;
            state          <= S_DONE;
          end else if (job_r.agent_a != job_r.agent_b) begin
            state <= S_X0;
          end else begin
            state <= S_COUNT;
          end
        end
        S_X0: begin
          state <= S_X1;
        end
        S_X1: begin
          pacc  <= P_W'(prod);
          state <= S_X2;
        end
        S_X2: begin
          pacc  <= P_W'(prod << HALF) + pacc;
          state <= S_X3;
        end
        S_X3: begin
          qacc  <= P_W'(prod);
          state <= S_X4;
        end
        S_X4: begin
          qacc  <= P_W'(prod << HALF) + qacc;
          state <= S_X5;
        end
        S_X5: begin
          neg   <= qacc > pacc;
          mag   <= (qacc > pacc) ? M_W'(qacc - pacc) : M_W'(pacc - qacc);
          state <= S_X6;
        end
        S_X6: begin
          state <= S_X7;
        end
        S_X7: begin
          tacc  <= T_W'(prod >> 16);
          state <= S_X8;
        end
        S_X8: begin
          tacc  <= tacc + T_W'(prod);
          state <= S_X9;
        end
        S_X9: begin
          tacc  <= tacc + T_W'(prod << HALF);
          state <= S_X10;
        end
        S_X10: begin
          wa    <= clamp_wealth(sum_a);
          wb    <= clamp_wealth(sum_b);
          state <= S_WR_A;
        end
        S_WR_A: begin
          state <= S_WR_B;
        end
        S_WR_B: begin
          state <= S_COUNT;
        end
        S_COUNT: begin
          cnt            <= cnt_new;
          peak           <= peak_new;
          tally          <= tally_new;
          res.accepted   <= 1'b1;
          res.wealth_a   <= wa;
          res.wealth_b   <= wb;
          res.pair_count <= cnt_new;
          res.max_count  <= peak_new;
          res.max_rises  <= tally_new;
          state          <= S_DONE;
        end
        S_DONE: begin
          if (ctl.take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/kinetic_wealth_exchange_step_core.sv
// Wealth exchange step engine for 256 agents. A transaction request reads both agents and
// their pair count, forms the acceptance weight, exchanges money and updates the count and
// peak tally. The weight is one outright when alpha is zero or the gap is below one unit;
// otherwise it takes two log2 passes and the exponent product (a one-bit-per-cycle
// normalizing shift of up to 23 steps for the gap and 39 for the count, plus 16 squarings
// per pass on the shared 32x32 multiplier) and, where needed, an exp2 stage whose 16
// square roots run on a restoring step unit at one root bit per cycle. An init request
// sweeps the 65536-entry count store one entry per cycle. After reset the same clearing
// pass runs and no request is taken until it ends; configuration writes are taken
// throughout.
module kinetic_wealth_exchange_step_core (
  input  logic                         clk,
  input  logic                         rst,
  kwe_req_if.sink                      req,
  kwe_rsp_if.source                    rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [kwe_pkg::PADDR_W-1:0]  paddr,
  input  logic [kwe_pkg::CFG_W-1:0]    pwdata,
  output logic [kwe_pkg::CFG_W-1:0]    prdata,
  output logic                         pready
);
  import kwe_pkg::*;

  cfg_t     cfg;
  job_t     job;
  eng_ctl_t ctl;
  eng_sts_t sts;
  result_t  res;
  reg_idx_t reg_idx;
  logic     start;
  logic     take;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.saving_fraction <= '0;
      cfg.alpha_exponent  <= '0;
      cfg.gamma_exponent  <= '0;
      cfg.opening_balance <= MONEY_W'(65536);
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_SAVING: cfg.saving_fraction <= pwdata[Q16_W-1:0];
        REG_ALPHA:  cfg.alpha_exponent  <= pwdata[Q16_W-1:0];
        REG_GAMMA:  cfg.gamma_exponent  <= pwdata[Q16_W-1:0];
        REG_START:  cfg.opening_balance <= pwdata[MONEY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SAVING: prdata = CFG_W'(cfg.saving_fraction);
      REG_ALPHA:  prdata = CFG_W'(cfg.alpha_exponent);
      REG_GAMMA:  prdata = CFG_W'(cfg.gamma_exponent);
      REG_START:  prdata = CFG_W'(cfg.opening_balance);
      default:    prdata = '0;
    endcase
  end

  assign job.command     = req.command;
  assign job.agent_a     = req.agent_a;
  assign job.agent_b     = req.agent_b;
  assign job.share_draw  = req.share_draw;
  assign job.accept_draw = req.accept_draw;

  assign req.ready = sts.idle;
  assign start     = req.valid && sts.idle;
  assign take      = sts.res_valid && (!rsp.valid || rsp.ready);
  assign ctl.start = start;
  assign ctl.take  = take;

  kwe_engine u_engine (
    .clk(clk), .rst(rst), .cfg(cfg), .job(job), .ctl(ctl), .sts(sts), .res(res)
  );

  // hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (take) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp.accepted   <= res.accepted;
      rsp.wealth_a   <= res.wealth_a;
      rsp.wealth_b   <= res.wealth_b;
      rsp.pair_count <= res.pair_count;
      rsp.max_count  <= res.max_count;
      rsp.max_rises  <= res.max_rises;
    end
  end

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start |=> !req.ready)
    else $error("request taken but engine still idle");

  a_sweep_after_reset: assert property (@(posedge clk)
    rst |=> !req.ready)
    else $error("request ready during clearing pass");

  a_rsp_from_engine: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(sts.res_valid))
    else $error("response raised without engine result");

  a_accept_counts: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.accepted) |-> (rsp.pair_count != '0))
    else $error("accepted transaction with zero pair count");

endmodule

### tb/kwe_step_checker.sv
module kwe_step_checker
  import kwe_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  kwe_req_if                 req,
  kwe_rsp_if                 rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [CFG_W-1:0]   pwdata,
  input  logic               pready,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] WEALTH_TOP = (64'd1 << WEALTH_W) - 1;
  localparam logic [63:0] ONE_Q16    = 64'd65536;

  logic [Q16_W-1:0]    lambda_q;
  logic [Q16_W-1:0]    alpha_q;
  logic [Q16_W-1:0]    gamma_q;
  logic [MONEY_W-1:0]  money_q;
  logic [WEALTH_W-1:0] purse [256];
  logic [COUNT_W-1:0]  ties [65536];
  logic [COUNT_W-1:0]  peak;
  logic [COUNT_W-1:0]  peak_rises;
  result_t             outlook_q [$];

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic [63:0] log2_fix(logic [63:0] x);
    int unsigned e;
    logic [63:0] m;
    logic [63:0] frac;
    e = 0;
    frac = 0;
    if (x == 0) return 0;
    while (e < 63 && (x >> (e + 1)) != 0) e++;
    m = (e > 30) ? (x >> (e - 30)) : (x << (30 - e));
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac <<= 1;
      if (m >= (64'd1 << 31)) begin
        frac |= 64'd1;
        m >>= 1;
      end
    end
    return (64'(e) << 16) + frac;
  endfunction

  function automatic logic [63:0] pow2_frac(logic [63:0] f);
    logic [63:0] x;
    logic [63:0] v;
    x = 64'd1 << 30;
    for (int i = 0; i < 16; i++) begin
      v = x << ((f >> i) & 64'd1);
      x = floor_sqrt(v << 30);
    end
    return x;
  endfunction

  function automatic logic [63:0] accept_weight(logic [63:0] wa, logic [63:0] wb,
                                                logic [63:0] cnt);
    logic [63:0]        gap;
    logic [63:0]        lg;
    logic [63:0]        lc;
    logic [63:0]        n;
    logic [63:0]        ip;
    logic [63:0]        f;
    logic [63:0]        x;
    logic [63:0]        sh;
    logic signed [63:0] e28;
    logic signed [63:0] e16;
    gap = (wa > wb) ? wa - wb : wb - wa;
    if (alpha_q == 0 || gap < (64'd1 << WEALTH_FRAC_BITS)) return ONE_Q16;
    lg = log2_fix(gap) - (64'(WEALTH_FRAC_BITS) << 16);
    lc = log2_fix(cnt + 1);
    e28 = $signed(64'(gamma_q) * lc) - $signed(64'(alpha_q) * lg);
    if (e28 >= 0) return ONE_Q16;
    e16 = -$signed((64'(-e28) + 64'd4095) >> 12);
    if (e16 >= 0) return ONE_Q16;
    n = 64'(-e16);
    ip = (n + 64'd65535) >> 16;
    f = (ip << 16) - n;
    x = pow2_frac(f);
    sh = 64'd14 + ip;
    return (sh >= 64) ? 64'd0 : (x >> sh);
  endfunction

  function automatic logic [63:0] clip_wealth(logic signed [63:0] v);
    if (v < 0) return 0;
    if (64'(v) > WEALTH_TOP) return WEALTH_TOP;
    return 64'(v);
  endfunction

  function automatic void load_agents();
    logic [63:0] w;
    w = 64'(money_q);
    if (WEALTH_FRAC_BITS >= 16) w = w << (WEALTH_FRAC_BITS - 16);
    else w = w >> (16 - WEALTH_FRAC_BITS);
    w &= WEALTH_TOP;
    for (int i = 0; i < 256; i++) purse[i] = (i < AGENT_SPAN) ? w[WEALTH_W-1:0] : '0;
    for (int i = 0; i < 65536; i++) ties[i] = '0;
    peak = '0;
    peak_rises = '0;
  endfunction

  function automatic result_t trade_outcome(logic cmd, logic [7:0] a, logic [7:0] b,
                                            logic [15:0] eps, logic [15:0] draw);
    result_t            r;
    logic               a_ok;
    logic               b_ok;
    logic [63:0]        wa;
    logic [63:0]        wb;
    logic [63:0]        c;
    logic [63:0]        p;
    logic [63:0]        q;
    logic [63:0]        mag;
    logic [63:0]        oml;
    logic [63:0]        d;
    logic               neg;
    logic signed [63:0] sd;
    r = '0;
    a_ok = int'(a) < AGENT_SPAN;
    b_ok = int'(b) < AGENT_SPAN;
    if (cmd == CMD_INIT) begin
      load_agents();
    end else if (a_ok && b_ok) begin
      wa = 64'(purse[a]);
      wb = 64'(purse[b]);
      c = 64'(ties[{a, b}]);
      if (accept_weight(wa, wb, c) >= 64'(draw)) begin
        r.accepted = 1'b1;
        if (a != b) begin
          p = 64'(eps) * wb;
          q = (ONE_Q16 - 64'(eps)) * wa;
          neg = q > p;
          mag = neg ? q - p : p - q;
          oml = ONE_Q16 - 64'(lambda_q);
          d = ((mag >> 16) * oml + (((mag & 64'hFFFF) * oml) >> 16)) >> 16;
          sd = neg ? -$signed(d) : $signed(d);
          purse[a] = clip_wealth($signed(wa) + sd);
          purse[b] = clip_wealth($signed(wb) - sd);
        end
        if (c < 65535) c++;
        ties[{a, b}] = c[15:0];
        ties[{b, a}] = c[15:0];
        if (64'(peak) < c) begin
          peak = c[15:0];
          if (peak_rises < 16'hFFFF) peak_rises++;
        end
      end
      r.pair_count = ties[{a, b}];
    end
    if (a_ok && (cmd == CMD_INIT || b_ok)) r.wealth_a = purse[a];
    if (b_ok && (cmd == CMD_INIT || a_ok)) r.wealth_b = purse[b];
    r.max_count = peak;
    r.max_rises = peak_rises;
    return r;
  endfunction

  task automatic flag(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t %s: expected %0h, got %0h", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      lambda_q = '0;
      alpha_q = '0;
      gamma_q = '0;
      money_q = 24'd65536;
      for (int i = 0; i < 256; i++) purse[i] = '0;
      for (int i = 0; i < 65536; i++) ties[i] = '0;
      peak = '0;
      peak_rises = '0;
      errors = 0;
      outlook_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_SAVING: lambda_q = pwdata[15:0];
          REG_ALPHA:  alpha_q = pwdata[15:0];
          REG_GAMMA:  gamma_q = pwdata[15:0];
          REG_START:  money_q = pwdata[23:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready)
        outlook_q.push_back(trade_outcome(req.command, req.agent_a, req.agent_b,
                                          req.share_draw, req.accept_draw));
      if (rsp.valid && rsp.ready) begin
        if (outlook_q.size() == 0) begin
          $display("%0t unexpected response: expected none, got %0h", $time, rsp.wealth_a);
          errors++;
        end else begin
          want = outlook_q.pop_front();
          flag("accepted", 64'(want.accepted), 64'(rsp.accepted));
          flag("wealth_a", 64'(want.wealth_a), 64'(rsp.wealth_a));
          flag("wealth_b", 64'(want.wealth_b), 64'(rsp.wealth_b));
          flag("pair_count", 64'(want.pair_count), 64'(rsp.pair_count));
          flag("max_count", 64'(want.max_count), 64'(rsp.max_count));
          flag("max_rises", 64'(want.max_rises), 64'(rsp.max_rises));
        end
      end
    end
    pending <= outlook_q.size();
  end

endmodule

### tb/tb_kinetic_wealth_exchange_step_core.sv
module tb_kinetic_wealth_exchange_step_core;
  import kwe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [CFG_W-1:0]   pwdata;
  logic [CFG_W-1:0]   prdata;
  logic               pready;
  logic               calm;
  int                 errors;
  int                 pending;

  kwe_req_if req_bus ();
  kwe_rsp_if rsp_bus ();

  kinetic_wealth_exchange_step_core u_dut (
    .clk(clk), .rst(rst), .req(req_bus.sink), .rsp(rsp_bus.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  kwe_step_checker u_checker (
    .clk(clk), .rst(rst), .req(req_bus), .rsp(rsp_bus),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("kinetic_wealth_exchange_step_core: mismatch");
    $finish;
  end

  always @(posedge clk)
    rsp_bus.ready <= !rst && (calm || $urandom_range(99) >= 7);

  task automatic send_request(logic cmd, logic [7:0] a, logic [7:0] b,
                              logic [15:0] eps, logic [15:0] draw);
    if (!calm && $urandom_range(99) < 7) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.command <= cmd;
    req_bus.agent_a <= a;
    req_bus.agent_b <= b;
    req_bus.share_draw <= eps;
    req_bus.accept_draw <= draw;
    do @(posedge clk); while (!req_bus.ready);
  endtask

  task automatic drain();
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(idx) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic setup(logic [15:0] lam, logic [15:0] alp, logic [15:0] gam,
                       logic [23:0] money);
    drain();
    write_reg(REG_SAVING, 32'(lam));
    write_reg(REG_ALPHA, 32'(alp));
    write_reg(REG_GAMMA, 32'(gam));
    write_reg(REG_START, 32'(money));
    send_request(CMD_INIT, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic random_trades(int count);
    logic [7:0]  a;
    logic [7:0]  b;
    logic [15:0] draw;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 60) begin
        a = 8'($urandom_range(7) * 33);
        b = 8'($urandom_range(7) * 33);
      end else begin
        a = 8'($urandom);
        b = 8'($urandom);
      end
      draw = ($urandom_range(99) < 30) ? 16'($urandom_range(255)) : 16'($urandom);
      send_request(CMD_XFER, a, b, 16'($urandom), draw);
    end
  endtask

  initial begin
    rst = 1'b1;
    calm = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_bus.valid = 1'b0;
    req_bus.command = CMD_INIT;
    req_bus.agent_a = '0;
    req_bus.agent_b = '0;
    req_bus.share_draw = '0;
    req_bus.accept_draw = '0;
    rsp_bus.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_request(CMD_XFER, 8'd0, 8'd255, 16'd0, 16'hFFFF);
    send_request(CMD_XFER, 8'd255, 8'd255, 16'hFFFF, 16'd0);

    setup(16'd0, 16'd0, 16'd0, 24'd65536);
    send_request(CMD_XFER, 8'd0, 8'd255, 16'hFFFF, 16'hFFFF);
    send_request(CMD_XFER, 8'd255, 8'd0, 16'd0, 16'd0);
    send_request(CMD_XFER, 8'd5, 8'd5, 16'h8000, 16'd0);
    send_request(CMD_XFER, 8'd0, 8'd255, 16'h1234, 16'h0001);
    send_request(CMD_XFER, 8'd1, 8'd2, 16'h4000, 16'hFFFF);

    setup(16'hFFFF, 16'd4096, 16'hFFFF, 24'hFFFFFF);
    send_request(CMD_XFER, 8'd0, 8'd1, 16'hFFFF, 16'd0);
    send_request(CMD_XFER, 8'd0, 8'd1, 16'd0, 16'd0);
    send_request(CMD_XFER, 8'd1, 8'd0, 16'hFFFF, 16'h8000);
    send_request(CMD_XFER, 8'd3, 8'd3, 16'd0, 16'hFFFF);

    setup(16'd0, 16'hFFFF, 16'd0, 24'hFFFFFF);
    send_request(CMD_XFER, 8'd10, 8'd20, 16'hFFFF, 16'd0);
    send_request(CMD_XFER, 8'd10, 8'd20, 16'hFFFF, 16'd0);
    send_request(CMD_XFER, 8'd20, 8'd10, 16'h0001, 16'd1);
    send_request(CMD_XFER, 8'd20, 8'd10, 16'h0001, 16'hFFFF);

    setup(16'($urandom), 16'd2048, 16'd8192, 24'h200000);
    random_trades(480);
    setup(16'hFFFF, 16'($urandom_range(12288)), 16'hFFFF, 24'($urandom));
    random_trades(480);
    calm = 1'b1;
    setup(16'd0, 16'($urandom), 16'($urandom), 24'hFFFFFF);
    random_trades(300);
    calm = 1'b0;
    setup(16'($urandom), 16'($urandom_range(8192)), 16'($urandom), 24'($urandom));
    random_trades(450);

    calm = 1'b1;
    setup(16'd0, 16'd0, 16'd0, 24'd65536);
    for (int i = 0; i < 40; i++) begin
      if (i[0]) send_request(CMD_XFER, 8'd9, 8'd3, 16'($urandom), 16'($urandom));
      else send_request(CMD_XFER, 8'd3, 8'd9, 16'($urandom), 16'($urandom));
    end
    calm = 1'b0;
    random_trades(200);

    drain();
    repeat (1000) @(posedge clk);
    if (errors == 0) begin
      $display("kinetic_wealth_exchange_step_core: match");
    end else begin
      $display("kinetic_wealth_exchange_step_core: mismatch");
    end
    $finish;
  end

endmodule
